// ===== hdl/sdi_pkg.sv =====
// Shared types, phase encoding and command tables for the SD card SPI init sequencer.
// No dependencies; imported by sdi_step and sd_spi_init_sequencer.
`timescale 1ns / 1ps

package sdi_pkg;

    typedef logic [4:0] t_phase;
    typedef logic [2:0] t_cmd;
    typedef logic [2:0] t_fail;
    typedef logic [1:0] t_cfg_index;

    // Request kinds carried in the input tuser.
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_XFER  = 1'b1;

    // Phase encoding. Command frames and response waits occupy one phase per command,
    // and the failure phases sit above PH_FAIL, offset by the failure code.
    localparam t_phase PH_IDLE  = 5'd0;
    localparam t_phase PH_WAKE  = 5'd1;
    localparam t_phase PH_FRAME = 5'd2;
    localparam t_phase PH_POLL  = 5'd7;
    localparam t_phase PH_R7    = 5'd12;
    localparam t_phase PH_OCR   = 5'd13;
    localparam t_phase PH_OK    = 5'd14;
    localparam t_phase PH_FAIL  = 5'd14;

    localparam t_cmd CMD_0   = 3'd0;
    localparam t_cmd CMD_8   = 3'd1;
    localparam t_cmd CMD_55  = 3'd2;
    localparam t_cmd ACMD_41 = 3'd3;
    localparam t_cmd CMD_58  = 3'd4;

    localparam t_fail FAIL_NONE   = 3'd0;
    localparam t_fail FAIL_CMD0   = 3'd1;
    localparam t_fail FAIL_CMD8   = 3'd2;
    localparam t_fail FAIL_ECHO   = 3'd3;
    localparam t_fail FAIL_CMD55  = 3'd4;
    localparam t_fail FAIL_ACMD41 = 3'd5;
    localparam t_fail FAIL_CMD58  = 3'd6;

    localparam t_cfg_index CFG_POLL_LIMIT  = 2'd0;
    localparam t_cfg_index CFG_READY_LIMIT = 2'd1;
    localparam t_cfg_index CFG_WAKE_COUNT  = 2'd2;

    localparam logic [7:0] BYTE_IDLE    = 8'hFF;
    localparam logic [7:0] CMD_START    = 8'h40;
    localparam logic [7:0] R1_IDLE      = 8'h01;
    localparam logic [7:0] R1_READY     = 8'h00;
    localparam logic [7:0] R7_VOLTAGE   = 8'h01;
    localparam logic [7:0] R7_PATTERN   = 8'hAA;
    localparam logic [7:0] FRAME_LEN    = 8'd8;
    localparam logic [7:0] TRAILER_LEN  = 8'd4;

    typedef struct packed {
        logic [7:0] poll_limit;
        logic [7:0] ready_limit;
        logic [7:0] wake_count;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{poll_limit: 8'd20, ready_limit: 8'd20, wake_count: 8'd10};

    typedef struct packed {
        t_phase     phase;
        logic [7:0] byte_index;
        logic [7:0] poll_count;
        logic [7:0] ready_attempts;
        logic       echo_ok;
        logic       capacity_flag;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase: PH_IDLE, byte_index: 8'd0, poll_count: 8'd0,
        ready_attempts: 8'd0, echo_ok: 1'b1, capacity_flag: 1'b0
    };

    // Packed so that tx_byte lands in the lowest bits of the output tdata.
    typedef struct packed {
        t_fail      fail_code;
        logic       high_capacity;
        logic       init_ok;
        logic       finished;
        logic       transfer_valid;
        logic       cs_high;
        logic [7:0] tx_byte;
    } t_result;

    function automatic t_fail cmd_fail_code(input t_cmd cmd);
        t_fail code;
        unique case (cmd)
            CMD_0:   code = FAIL_CMD0;
            CMD_8:   code = FAIL_CMD8;
            CMD_55:  code = FAIL_CMD55;
            ACMD_41: code = FAIL_ACMD41;
            default: code = FAIL_CMD58;
        endcase
        return code;
    endfunction

    // Byte of a command frame at a given position: two idle bytes, start/index,
    // four argument bytes (big-endian), CRC.
    function automatic logic [7:0] cmd_frame_byte(input t_cmd cmd, input logic [7:0] idx);
        logic [7:0]  index;
        logic [31:0] arg;
        logic [7:0]  crc;
        logic [7:0]  b;
        unique case (cmd)
            CMD_0:   begin index = 8'h00; arg = 32'h0000_0000; crc = 8'h95; end
            CMD_8:   begin index = 8'h08; arg = 32'h0000_01AA; crc = 8'h87; end
            CMD_55:  begin index = 8'h37; arg = 32'h0000_0000; crc = 8'h01; end
            ACMD_41: begin index = 8'h29; arg = 32'h4000_0000; crc = 8'h01; end
            default: begin index = 8'h3A; arg = 32'h0000_0000; crc = 8'h01; end
        endcase
        unique case (idx)
            8'd2:    b = CMD_START | index;
            8'd3:    b = arg[31:24];
            8'd4:    b = arg[23:16];
            8'd5:    b = arg[15:8];
            8'd6:    b = arg[7:0];
            8'd7:    b = crc;
            default: b = BYTE_IDLE;
        endcase
        return b;
    endfunction

endpackage

// ===== hdl/sd_spi_init_sequencer.sv =====
// Top level of the SD card SPI-mode init sequencer: input register, state, result register.
// Depends on sdi_pkg and sdi_step.
//
//   Channel   Direction  Signals                        Contents
//   s         in         i_s_tvalid/o_s_tready          tuser: req_type; tdata: rx_byte
//   m         out        o_m_tvalid/i_m_tready          tdata: tx_byte, cs_high, transfer_valid,
//                                                       finished, init_ok, high_capacity, fail_code
//   cfg       in         i_cfg_we/i_cfg_index/wdata     poll limit, ready limit, wake count
//
// One item is accepted per cycle while o_s_tready is high. Its result goes from the input
// register through one pass into the state and result registers, and then on the output.
// Reset puts the sequencer in idle and the registers at 20, 20 and 10.
// When i_m_tready is low the result register holds, one more item can wait in the
// input register, and o_s_tready then drops until the result is taken.
`timescale 1ns / 1ps

module sd_spi_init_sequencer import sdi_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    input  logic [0:0]  i_s_tuser,   // [0] req_type
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [7:0] tx_byte, [8] cs_high, [9] transfer_valid,
                                     // [10] finished, [11] init_ok, [12] high_capacity,
                                     // [15:13] fail_code
    input  logic        i_cfg_we,
    input  t_cfg_index  i_cfg_index,
    input  logic [7:0]  i_cfg_wdata
);

    t_cfg       r_cfg;
    t_state     r_state;
    logic       r_in_valid;
    logic       r_in_req;
    logic [7:0] r_in_rx;
    logic       r_out_valid;
    t_result    r_out;

    t_state     n_state;
    t_result    n_out;
    logic       advance;
    logic       accept;

    sdi_step u_step (
        .i_state    (r_state),
        .i_cfg      (r_cfg),
        .i_req_type (r_in_req),
        .i_rx_byte  (r_in_rx),
        .o_state    (n_state),
        .o_result   (n_out)
    );

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign accept     = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= CFG_RESET;
            r_state     <= STATE_RESET;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_POLL_LIMIT:  r_cfg.poll_limit  <= i_cfg_wdata;
                    CFG_READY_LIMIT: r_cfg.ready_limit <= i_cfg_wdata;
                    CFG_WAKE_COUNT:  r_cfg.wake_count  <= i_cfg_wdata;
                    default:         r_cfg             <= r_cfg;
                endcase
            end
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_req <= i_s_tuser[0];
            r_in_rx  <= i_s_tdata;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

endmodule

// ===== hdl/sdi_step.sv =====
// Next-state and result logic of the SD card SPI init sequencer for one item.
// Purely combinational; depends on sdi_pkg.
`timescale 1ns / 1ps

module sdi_step import sdi_pkg::*; (
    input  t_state     i_state,
    input  t_cfg       i_cfg,
    input  logic       i_req_type,
    input  logic [7:0] i_rx_byte,
    output t_state     o_state,
    output t_result    o_result
);

    function automatic t_state f_start_attempt(input t_state s, input t_cfg c);
        t_state r;
        r = s;
        if (s.ready_attempts >= c.ready_limit) begin
            r.phase = PH_FAIL + 5'(FAIL_ACMD41);
        end else begin
            r.ready_attempts = s.ready_attempts + 8'd1;
            r.phase          = PH_FRAME + 5'(CMD_55);
            r.byte_index     = 8'd0;
            r.poll_count     = 8'd0;
        end
        return r;
    endfunction

    // A wait that ran out: ACMD41 counts it as a not-ready answer and tries again.
    function automatic t_state f_timeout(input t_state s, input t_cfg c, input t_cmd cmd);
        t_state r;
        r = s;
        if (cmd == ACMD_41) begin
            r = f_start_attempt(s, c);
        end else begin
            r.phase = PH_FAIL + 5'(cmd_fail_code(cmd));
        end
        return r;
    endfunction

    // Entering a phase clears the counters; an empty wake run or an empty poll
    // budget falls straight through to what follows.
    function automatic t_state f_enter(input t_state s, input t_cfg c, input t_phase ph);
        t_state r;
        r            = s;
        r.phase      = ph;
        r.byte_index = 8'd0;
        r.poll_count = 8'd0;
        if (ph == PH_WAKE && c.wake_count == 8'd0) begin
            r.phase = PH_FRAME + 5'(CMD_0);
        end else if (ph >= PH_POLL && ph < PH_R7 && c.poll_limit == 8'd0) begin
            r = f_timeout(r, c, 3'(ph - PH_POLL));
        end
        return r;
    endfunction

    function automatic t_state f_response(input t_state s, input t_cfg c, input t_cmd cmd,
                                          input logic [7:0] rx);
        t_state r;
        r = s;
        unique case (cmd)
            CMD_0: begin
                if (rx == R1_IDLE) r = f_enter(s, c, PH_FRAME + 5'(CMD_8));
                else r.phase = PH_FAIL + 5'(FAIL_CMD0);
            end
            CMD_8: begin
                if (rx == R1_IDLE) begin
                    r.echo_ok = 1'b1;
                    r = f_enter(r, c, PH_R7);
                end else begin
                    r.phase = PH_FAIL + 5'(FAIL_CMD8);
                end
            end
            CMD_55: begin
                if (rx == R1_IDLE) r = f_enter(s, c, PH_FRAME + 5'(ACMD_41));
                else r.phase = PH_FAIL + 5'(FAIL_CMD55);
            end
            ACMD_41: begin
                if (rx == R1_READY) r = f_enter(s, c, PH_FRAME + 5'(CMD_58));
                else r = f_start_attempt(s, c);
            end
            default: begin
                if (rx == R1_READY) begin
                    r.capacity_flag = 1'b0;
                    r = f_enter(r, c, PH_OCR);
                end else begin
                    r.phase = PH_FAIL + 5'(FAIL_CMD58);
                end
            end
        endcase
        return r;
    endfunction

    t_state     nx;
    t_result    res;
    logic [7:0] bi_inc;
    logic [7:0] pc_inc;
    t_cmd       frame_cmd;
    t_cmd       poll_cmd;
    t_cmd       out_cmd;
    logic       echo;

    assign bi_inc    = i_state.byte_index + 8'd1;
    assign pc_inc    = i_state.poll_count + 8'd1;
    assign frame_cmd = 3'(i_state.phase - PH_FRAME);
    assign poll_cmd  = 3'(i_state.phase - PH_POLL);

    always_comb begin
        nx   = i_state;
        echo = i_state.echo_ok;
        if (i_req_type == REQ_START) begin
            nx.ready_attempts = 8'd0;
            nx.echo_ok        = 1'b1;
            nx.capacity_flag  = 1'b0;
            nx = f_enter(nx, i_cfg, PH_WAKE);
        end else if (i_state.phase >= PH_WAKE && i_state.phase <= PH_OCR) begin
            priority if (i_state.phase == PH_WAKE) begin
                nx.byte_index = bi_inc;
                if (bi_inc >= i_cfg.wake_count) nx = f_enter(nx, i_cfg, PH_FRAME + 5'(CMD_0));
            end else if (i_state.phase < PH_POLL) begin
                nx.byte_index = bi_inc;
                if (bi_inc >= FRAME_LEN) nx = f_enter(nx, i_cfg, PH_POLL + 5'(frame_cmd));
            end else if (i_state.phase < PH_R7) begin
                nx.poll_count = pc_inc;
                if (!i_rx_byte[7]) begin
                    nx = f_response(nx, i_cfg, poll_cmd, i_rx_byte);
                end else if (pc_inc >= i_cfg.poll_limit) begin
                    nx = f_timeout(nx, i_cfg, poll_cmd);
                end
            end else if (i_state.phase == PH_R7) begin
                // R7 trailer: bytes two and three carry the voltage and check pattern.
                if (i_state.byte_index == 8'd2 && i_rx_byte != R7_VOLTAGE) echo = 1'b0;
                if (i_state.byte_index == 8'd3 && i_rx_byte != R7_PATTERN) echo = 1'b0;
                nx.echo_ok    = echo;
                nx.byte_index = bi_inc;
                if (bi_inc >= TRAILER_LEN) begin
                    if (echo) begin
                        nx.ready_attempts = 8'd0;
                        nx = f_start_attempt(nx, i_cfg);
                    end else begin
                        nx.phase = PH_FAIL + 5'(FAIL_ECHO);
                    end
                end
            end else begin
                // First OCR byte holds the card capacity status bit.
                if (i_state.byte_index == 8'd0) nx.capacity_flag = i_rx_byte[6];
                nx.byte_index = bi_inc;
                if (bi_inc >= TRAILER_LEN) nx.phase = PH_OK;
            end
        end
    end

    assign out_cmd = 3'(nx.phase - PH_FRAME);

    always_comb begin
        res                = '0;
        res.tx_byte        = BYTE_IDLE;
        res.cs_high        = 1'b1;
        res.transfer_valid = 1'b1;
        priority if (nx.phase == PH_WAKE) begin
            res.cs_high = 1'b1;
        end else if (nx.phase >= PH_FRAME && nx.phase < PH_POLL) begin
            res.cs_high = (nx.byte_index == 8'd0);
            res.tx_byte = cmd_frame_byte(out_cmd, nx.byte_index);
        end else if (nx.phase >= PH_POLL && nx.phase <= PH_OCR) begin
            res.cs_high = 1'b0;
        end else begin
            res.transfer_valid = 1'b0;
            if (nx.phase == PH_OK) begin
                res.finished      = 1'b1;
                res.init_ok       = 1'b1;
                res.high_capacity = nx.capacity_flag;
            end else if (nx.phase > PH_FAIL && nx.phase <= PH_FAIL + 5'(FAIL_CMD58)) begin
                res.finished  = 1'b1;
                res.fail_code = 3'(nx.phase - PH_FAIL);
            end
        end
    end

    assign o_state  = nx;
    assign o_result = res;

endmodule
